// ----- rtl/tbsa_pkg.sv -----
// package for the two-button setpoint adjuster: words, config codes, button step
`timescale 1ns / 1ps
`default_nettype none

package tbsa_pkg;

	localparam int CNT_W = 8;
	localparam int SP_W = 8;
	localparam int STEP_W = 7;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [SP_W-1:0] SETPOINT_RESET = 8'hF7;

	localparam logic [CNT_W-1:0] PRESS_TH_RESET = 8'd5;
	localparam logic [CNT_W-1:0] HOLD_TH_RESET = 8'd20;
	localparam logic [CNT_W-1:0] REPEAT_DELAY_RESET = 8'd70;
	localparam logic [STEP_W-1:0] COARSE_STEP_RESET = 7'd10;

	typedef enum logic [1:0] {
		REG_PRESS_TH = 2'd0,
		REG_HOLD_TH = 2'd1,
		REG_REPEAT_DELAY = 2'd2,
		REG_COARSE_STEP = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic plus_down;
		logic minus_down;
	} tick_word_t;

	typedef struct packed {
		logic signed [SP_W-1:0] setpoint;
		logic plus_pressed;
		logic plus_held;
		logic minus_pressed;
		logic minus_held;
	} result_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] press_th;
		logic [CNT_W-1:0] hold_th;
		logic [CNT_W-1:0] repeat_delay;
		logic [STEP_W-1:0] coarse_step;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] repeat_cnt;
		logic press;
		logic hold;
	} button_t;

	typedef struct packed {
		button_t btn;
		logic [SP_W-1:0] delta;
	} button_step_t;

	// one tick of one button; delta is unsigned magnitude, caller applies direction
	function automatic button_step_t button_tick(button_t b, logic down, cfg_t cfg);
		button_step_t r;
		logic [CNT_W-1:0] cnt_n;
		logic [CNT_W-1:0] rep_n;
		r.btn = b;
		r.delta = '0;
		cnt_n = (b.count < COUNT_MAX) ? b.count + 1'b1 : b.count;
		rep_n = b.repeat_cnt + 1'b1;
		if (down) begin
			r.btn.count = cnt_n;
			if (cnt_n > cfg.press_th) begin
				r.btn.press = 1'b1;
			end
			if (cnt_n > cfg.hold_th) begin
				r.btn.hold = 1'b1;
				if (rep_n > cfg.repeat_delay) begin
					r.delta = {1'b0, cfg.coarse_step};
					r.btn.repeat_cnt = '0;
				end else begin
					r.btn.repeat_cnt = rep_n;
				end
			end
		end else begin
			if (b.press && !b.hold) begin
				r.delta = {{(SP_W-1){1'b0}}, 1'b1};
			end
			r.btn = '0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/two_button_setpoint_adjuster.sv -----
// top level of the two-button setpoint adjuster with apb config registers
`timescale 1ns / 1ps
`default_nettype none

// an accepted tick word's result word is registered directly into the output register
// throughput: one tick word per cycle; tick_ready stays high while the output register
//   is empty or its word is taken in the same cycle
// the button state and setpoint update in the accept cycle, so only a stalled output register limits the rate
// reset: setpoint to -9, button counts and flags to zero, config registers to their defaults
module two_button_setpoint_adjuster (
	input wire logic clk,
	input wire logic arst_n,
	// tick channel
	input wire logic tick_valid,
	output logic tick_ready,
	input wire tbsa_pkg::tick_word_t tick,
	// result channel
	output logic result_valid,
	input wire logic result_ready,
	output tbsa_pkg::result_word_t result,
	// apb config port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tbsa_pkg::PADDR_W-1:0] paddr,
	input wire logic [tbsa_pkg::PDATA_W-1:0] pwdata,
	output logic [tbsa_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	// config registers
	tbsa_pkg::cfg_t cfg_q;

	// button and setpoint state
	tbsa_pkg::button_t plus_q;
	tbsa_pkg::button_t minus_q;
	logic [tbsa_pkg::SP_W-1:0] setpoint_q;

	// output register
	logic out_valid_q;
	tbsa_pkg::result_word_t out_word_q;

	// next-state logic
	tbsa_pkg::button_step_t plus_step;
	tbsa_pkg::button_step_t minus_step;
	logic [tbsa_pkg::SP_W-1:0] setpoint_n;
	logic tick_acc;
	logic cfg_wr;
	tbsa_pkg::reg_idx_t reg_idx;

	assign pready = 1'b1;
	assign reg_idx = tbsa_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite;

	// register read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			tbsa_pkg::REG_PRESS_TH: prdata = {24'd0, cfg_q.press_th};
			tbsa_pkg::REG_HOLD_TH: prdata = {24'd0, cfg_q.hold_th};
			tbsa_pkg::REG_REPEAT_DELAY: prdata = {24'd0, cfg_q.repeat_delay};
			tbsa_pkg::REG_COARSE_STEP: prdata = {25'd0, cfg_q.coarse_step};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_th <= tbsa_pkg::PRESS_TH_RESET;
			cfg_q.hold_th <= tbsa_pkg::HOLD_TH_RESET;
			cfg_q.repeat_delay <= tbsa_pkg::REPEAT_DELAY_RESET;
			cfg_q.coarse_step <= tbsa_pkg::COARSE_STEP_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tbsa_pkg::REG_PRESS_TH: cfg_q.press_th <= pwdata[7:0];
				tbsa_pkg::REG_HOLD_TH: cfg_q.hold_th <= pwdata[7:0];
				tbsa_pkg::REG_REPEAT_DELAY: cfg_q.repeat_delay <= pwdata[7:0];
				tbsa_pkg::REG_COARSE_STEP: cfg_q.coarse_step <= pwdata[6:0];
			endcase
		end
	end

	// output register acts as the decoupling stage: take a new word when it frees up
	assign tick_ready = !out_valid_q || result_ready;
	assign tick_acc = tick_valid && tick_ready;

	// plus is handled first, then minus; setpoint wraps mod 256
	always_comb begin
		plus_step = tbsa_pkg::button_tick(plus_q, tick.plus_down, cfg_q);
		minus_step = tbsa_pkg::button_tick(minus_q, tick.minus_down, cfg_q);
		setpoint_n = setpoint_q + plus_step.delta - minus_step.delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q <= '0;
			minus_q <= '0;
			setpoint_q <= tbsa_pkg::SETPOINT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				plus_q <= plus_step.btn;
				minus_q <= minus_step.btn;
				setpoint_q <= setpoint_n;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			out_word_q.setpoint <= setpoint_n;
			out_word_q.plus_pressed <= plus_step.btn.press;
			out_word_q.plus_held <= plus_step.btn.hold;
			out_word_q.minus_pressed <= minus_step.btn.press;
			out_word_q.minus_held <= minus_step.btn.hold;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_word_q;

endmodule

`default_nettype wire
